/* hdl/che_pkg.sv */
package che_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned DEG_W  = 4;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned ACC_W  = 65;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ZERO_LEAD = 2'd2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	typedef struct packed {
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
	} coef_t;

	// sequencer: TOP fetches the leading coefficient, M0..M6 run one Horner step
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TOP,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_M5,
		ST_M6,
		ST_DONE
	} state_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic fits;
		fits = (&v[ACC_W-1:DATA_W-1]) || (~|v[ACC_W-1:DATA_W-1]);
		if (fits) begin
			return v[DATA_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

endpackage

/* hdl/che_coef_store.sv */
module che_coef_store #(
	parameter int unsigned DEPTH  = 16,
	parameter int unsigned ADDR_W = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  che_pkg::coef_t      wr_data,
	input  logic [ADDR_W-1:0]   rd_addr,
	output che_pkg::coef_t      rd_data
);

	che_pkg::coef_t mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	che_pkg::coef_t   rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

/* hdl/complex_horner_evaluator.sv */
// Load item: accepted, passes through DONE, then result registered at the output.
// Evaluate item: TOP, then one Horner step per degree of n, paced by one
// shared 32x32 multiplier doing four products per Horner step.
// One item in flight; the next is taken while the last result waits.
// arst_n clears degree, coefficient store (valid bits) and sequencer.
module complex_horner_evaluator #(
	parameter int unsigned MAX_DEGREE = 15,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [3:0]         coef_index,
	input  logic signed [31:0] coef_re,
	input  logic signed [31:0] coef_im,
	input  logic signed [31:0] point_re,
	input  logic signed [31:0] point_im,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value_re,
	output logic signed [31:0] value_im,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_degree
);

	localparam int unsigned DEPTH = MAX_DEGREE + 1;
	localparam int unsigned SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = (SW > che_pkg::DEG_W) ? SW : che_pkg::DEG_W;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_DEGREE);

	che_pkg::state_t state_q, state_d;

	logic [che_pkg::DEG_W-1:0] degree_q;
	logic [CW-1:0]             deg_ext, n_eff, idx_ext;
	logic [SW-1:0]             idx_q;
	logic signed [31:0]        xr_q, xi_q, ar_q, ai_q, mr_q, mi_q;
	logic signed [63:0]        prod_q, mul_p;
	logic signed [31:0]        mul_a, mul_b;
	logic signed [che_pkg::ACC_W-1:0] sum_q;
	logic [che_pkg::STAT_W-1:0] stat_q, load_stat;
	logic                      accept, load_ok, out_load;

	logic                      wr_en;
	logic [SW-1:0]             rd_addr;
	che_pkg::coef_t            wr_data, coef;

	logic                      out_valid_q;
	logic signed [31:0]        value_re_q, value_im_q;
	logic [che_pkg::STAT_W-1:0] status_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			degree_q <= cfg_degree;
		end
	end

	assign deg_ext = CW'(degree_q);
	assign n_eff   = (deg_ext > MAX_C) ? MAX_C : deg_ext;
	assign idx_ext = CW'(coef_index);
	assign accept  = in_valid && !in_stall;

	always_comb begin
		load_stat = che_pkg::STAT_OK;
		if (idx_ext > n_eff) begin
			load_stat = che_pkg::STAT_BAD_INDEX;
		end else if (idx_ext == n_eff && n_eff != '0 && coef_re == '0 && coef_im == '0) begin
			load_stat = che_pkg::STAT_ZERO_LEAD;
		end
	end
	assign load_ok = (load_stat == che_pkg::STAT_OK);

	assign wr_data.re = coef_re;
	assign wr_data.im = coef_im;

	che_coef_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (SW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (idx_ext[SW-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (coef)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			che_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (req_type == che_pkg::REQ_EVAL) ? che_pkg::ST_TOP : che_pkg::ST_DONE;
				end
			end
			che_pkg::ST_TOP: begin
				state_d = (idx_q == '0) ? che_pkg::ST_DONE : che_pkg::ST_M0;
			end
			che_pkg::ST_M0: state_d = che_pkg::ST_M1;
			che_pkg::ST_M1: state_d = che_pkg::ST_M2;
			che_pkg::ST_M2: state_d = che_pkg::ST_M3;
			che_pkg::ST_M3: state_d = che_pkg::ST_M4;
			che_pkg::ST_M4: state_d = che_pkg::ST_M5;
			che_pkg::ST_M5: state_d = che_pkg::ST_M6;
			che_pkg::ST_M6: begin
				state_d = (idx_q == '0) ? che_pkg::ST_DONE : che_pkg::ST_M0;
			end
			che_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					state_d = che_pkg::ST_IDLE;
				end
			end
			default: state_d = che_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		wr_en    = 1'b0;
		out_load = 1'b0;
		rd_addr  = idx_q;
		mul_a    = ar_q;
		mul_b    = xr_q;
		case (state_q)
			che_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				rd_addr  = n_eff[SW-1:0];
				wr_en    = accept && (req_type == che_pkg::REQ_LOAD) && load_ok;
			end
			che_pkg::ST_M0: begin
				mul_a = ar_q;
				mul_b = xr_q;
			end
			che_pkg::ST_M1: begin
				mul_a = ai_q;
				mul_b = xi_q;
			end
			che_pkg::ST_M2: begin
				mul_a = ar_q;
				mul_b = xi_q;
			end
			che_pkg::ST_M3: begin
				mul_a = ai_q;
				mul_b = xr_q;
			end
			che_pkg::ST_DONE: begin
				out_load = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign mul_p = 64'(mul_a) * 64'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= che_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath: prod_q holds the last product, sum_q the 65-bit exact partial sum
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			che_pkg::ST_IDLE: begin
				if (accept) begin
					xr_q   <= point_re;
					xi_q   <= point_im;
					idx_q  <= n_eff[SW-1:0];
					ar_q   <= '0;
					ai_q   <= '0;
					stat_q <= (req_type == che_pkg::REQ_EVAL) ? che_pkg::STAT_OK : load_stat;
				end
			end
			che_pkg::ST_TOP: begin
				ar_q <= coef.re;
				ai_q <= coef.im;
				if (idx_q != '0) begin
					idx_q <= idx_q - 1'b1;
				end
			end
			che_pkg::ST_M1: begin
				sum_q <= che_pkg::ACC_W'(prod_q);
			end
			che_pkg::ST_M2: begin
				sum_q <= sum_q - che_pkg::ACC_W'(prod_q);
			end
			che_pkg::ST_M3: begin
				mr_q  <= che_pkg::sat32(sum_q >>> FRAC_BITS);
				sum_q <= che_pkg::ACC_W'(prod_q);
			end
			che_pkg::ST_M4: begin
				sum_q <= sum_q + che_pkg::ACC_W'(prod_q);
				ar_q  <= che_pkg::sat32(che_pkg::ACC_W'(mr_q) + che_pkg::ACC_W'(coef.re));
			end
			che_pkg::ST_M5: begin
				mi_q <= che_pkg::sat32(sum_q >>> FRAC_BITS);
			end
			che_pkg::ST_M6: begin
				ai_q <= che_pkg::sat32(che_pkg::ACC_W'(mi_q) + che_pkg::ACC_W'(coef.im));
				if (idx_q != '0) begin
					idx_q <= idx_q - 1'b1;
				end
			end
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_re_q <= ar_q;
			value_im_q <= ai_q;
			status_q   <= stat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value_re  = value_re_q;
	assign value_im  = value_im_q;
	assign status    = status_q;

endmodule

/* hdl/che_checker.sv */
module che_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] value_re,
	input logic [31:0] value_im,
	input logic [1:0]  status
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value_re) && $stable(value_im)
			&& $stable(status))
		else $error("result beat changed while stalled");

	// one item at a time: busy right after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous item in progress");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == che_pkg::STAT_OK || status == che_pkg::STAT_BAD_INDEX
			|| status == che_pkg::STAT_ZERO_LEAD))
		else $error("undefined status code");

	// rejected loads carry a zero value
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != che_pkg::STAT_OK |-> value_re == '0 && value_im == '0)
		else $error("rejected load with nonzero value");

endmodule

bind complex_horner_evaluator che_checker u_che_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.value_re  (value_re),
	.value_im  (value_im),
	.status    (status)
);
